>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RC4 keystream generator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define RC4KS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition is followed by another in the next cycle
`define RC4KS_ASSERT_NEXT(label, cond, follow, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (follow)) \
      else $error(msg);

`else

`define RC4KS_ASSERT(label, prop, msg)
`define RC4KS_ASSERT_NEXT(label, cond, follow, msg)

`endif

`endif

>>> hdl/rc4ks_pkg.sv
// ----------------------------------------------------------------------------
// rc4ks_pkg
// Shared types and constants for the RC4 keystream generator.
// ----------------------------------------------------------------------------
package rc4ks_pkg;

   localparam int TABLE_DEPTH   = 256;
   localparam int IDX_W         = 8;
   localparam int KEY_BYTES_MAX = 256;
   localparam int KCNT_W        = 9;

   typedef logic [IDX_W-1:0]  byte_type;
   typedef logic [KCNT_W-1:0] kcnt_type;

   // operation codes of a transaction
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // key byte write into the key buffer
   typedef struct packed {
      logic     valid;
      byte_type data;
      logic     last;
   } key_wr_type;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_INIT = 9'b000000001,
      ST_IDLE = 9'b000000010,
      ST_DJ   = 9'b000000100,
      ST_DWI  = 9'b000001000,
      ST_DWJ  = 9'b000010000,
      ST_KRD  = 9'b000100000,
      ST_KJ   = 9'b001000000,
      ST_KWK  = 9'b010000000,
      ST_KWJ  = 9'b100000000
   } state_type;

endpackage

>>> hdl/rc4ks_key_buf.sv
// ----------------------------------------------------------------------------
// rc4ks_key_buf
// Key byte buffer: one write port fed by load transactions, one registered
// read port used by the key schedule, and the saturating fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4ks_key_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  rc4ks_pkg::key_wr_type key_wr,
   input  rc4ks_pkg::byte_type   rd_addr,
   output rc4ks_pkg::byte_type   rd_data,
   output rc4ks_pkg::kcnt_type   sched_len
);
   import rc4ks_pkg::*;

   byte_type key_mem [KEY_BYTES_MAX];
   byte_type rd_data_ff;
   kcnt_type count_ff;
   kcnt_type count_in;
   logic     has_room;

   // room left while fewer than the maximum bytes are held
   assign has_room  = (count_ff < KCNT_W'(KEY_BYTES_MAX));
   // length the schedule sees, including a byte written this cycle
   assign sched_len = has_room ? count_ff + 1'b1 : count_ff;
   assign rd_data   = rd_data_ff;

   // advance the count on a load, drop it to zero on the last byte
   always_comb begin
      count_in = count_ff;
      if (key_wr.valid) begin
         if (key_wr.last) begin
            count_in = '0;
         end else if (has_room) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // store the byte while room is left; registered read
   always_ff @(posedge clock) begin
      if (key_wr.valid && has_room) begin
         key_mem[count_ff[IDX_W-1:0]] <= key_wr.data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   `RC4KS_ASSERT(a_count_bound, count_ff <= KCNT_W'(KEY_BYTES_MAX), "key count overflow")
   `RC4KS_ASSERT_NEXT(a_count_clear, key_wr.valid && key_wr.last, count_ff == '0, "key count not cleared")
   `RC4KS_ASSERT_NEXT(a_count_step, key_wr.valid && !key_wr.last && has_room, count_ff == $past(count_ff) + 1'b1, "key count did not advance")

endmodule

>>> hdl/rc4ks_perm_engine.sv
// ----------------------------------------------------------------------------
// rc4ks_perm_engine
// State table memory with its read-modify-write sequencer: identity fill,
// key schedule swaps and keystream draws.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4ks_perm_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                operation,
   input  logic                key_last,
   input  rc4ks_pkg::kcnt_type sched_len,
   output rc4ks_pkg::byte_type key_rd_addr,
   input  rc4ks_pkg::byte_type key_rd_data,
   output logic                busy,
   output logic                rsp_valid,
   output rc4ks_pkg::byte_type rsp_random_byte
);
   import rc4ks_pkg::*;

   byte_type  perm_mem [TABLE_DEPTH];
   byte_type  perm_rd_ff;

   state_type state_ff, state_in;
   byte_type  ctr_ff, ctr_in;
   byte_type  kpos_ff, kpos_in;
   kcnt_type  len_ff, len_in;
   logic      sched_ff, sched_in;
   byte_type  i_ff, i_in;
   byte_type  j_ff, j_in;
   byte_type  si_ff, si_in;
   byte_type  sj_ff, sj_in;
   byte_type  t_ff, t_in;
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_byte_ff, rsp_byte_in;

   byte_type  rd_addr;
   logic      wr_en;
   byte_type  wr_addr;
   byte_type  wr_data;

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_byte = rsp_byte_ff;
   assign key_rd_addr     = kpos_ff;

   // sequencer
   always_comb begin
      byte_type jn;
      byte_type tn;
      jn           = '0;
      tn           = '0;
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      kpos_in      = kpos_ff;
      len_in       = len_ff;
      sched_in     = sched_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rd_addr      = i_ff + 1'b1;
      wr_en        = 1'b0;
      wr_addr      = ctr_ff;
      wr_data      = ctr_ff;
      unique case (state_ff)
         ST_INIT: begin
            // fill the table with the identity, one entry per cycle
            wr_en  = 1'b1;
            ctr_in = ctr_ff + 1'b1;
            if (ctr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = sched_ff ? ST_KRD : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (operation == OP_DRAW) begin
                  // advance i and fetch S[i]
                  i_in     = i_ff + 1'b1;
                  state_in = ST_DJ;
               end else if (key_last) begin
                  len_in   = sched_len;
                  sched_in = 1'b1;
                  j_in     = '0;
                  kpos_in  = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_DJ: begin
            // add S[i] into j and fetch S[j]
            jn       = j_ff + perm_rd_ff;
            si_in    = perm_rd_ff;
            j_in     = jn;
            rd_addr  = jn;
            state_in = ST_DWI;
         end
         ST_DWI: begin
            // write S[j] into slot i and fetch the output entry
            tn       = si_ff + perm_rd_ff;
            sj_in    = perm_rd_ff;
            t_in     = tn;
            rd_addr  = tn;
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = perm_rd_ff;
            state_in = ST_DWJ;
         end
         ST_DWJ: begin
            // write S[i] into slot j; forward swapped entries to the output
            wr_en        = 1'b1;
            wr_addr      = j_ff;
            wr_data      = si_ff;
            rsp_valid_in = 1'b1;
            if (t_ff == j_ff) begin
               rsp_byte_in = si_ff;
            end else if (t_ff == i_ff) begin
               rsp_byte_in = sj_ff;
            end else begin
               rsp_byte_in = perm_rd_ff;
            end
            state_in = ST_IDLE;
         end
         ST_KRD: begin
            // fetch S[k]; key byte is read at kpos
            rd_addr  = ctr_ff;
            state_in = ST_KJ;
         end
         ST_KJ: begin
            jn       = j_ff + perm_rd_ff + key_rd_data;
            si_in    = perm_rd_ff;
            j_in     = jn;
            rd_addr  = jn;
            state_in = ST_KWK;
         end
         ST_KWK: begin
            wr_en    = 1'b1;
            wr_addr  = ctr_ff;
            wr_data  = perm_rd_ff;
            state_in = ST_KWJ;
         end
         ST_KWJ: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = si_ff;
            ctr_in  = ctr_ff + 1'b1;
            // cycle through the key bytes held
            if ({1'b0, kpos_ff} + 1'b1 == len_ff) begin
               kpos_in = '0;
            end else begin
               kpos_in = kpos_ff + 1'b1;
            end
            if (ctr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               i_in     = '0;
               j_in     = '0;
               sched_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KRD;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ctr_ff       <= '0;
         kpos_ff      <= '0;
         sched_ff     <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         kpos_ff      <= kpos_in;
         sched_ff     <= sched_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // state table: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      perm_rd_ff <= perm_mem[rd_addr];
   end

   `RC4KS_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held two cycles")
   `RC4KS_ASSERT(a_draw_latency, (accept && operation == OP_DRAW) |-> ##4 rsp_valid_ff, "draw gave no result")
   `RC4KS_ASSERT(a_swap_order, (state_ff == ST_KWJ) |-> ($past(state_ff) == ST_KWK), "swap write out of order")
   `RC4KS_ASSERT_NEXT(a_no_rsp_load, accept && operation == OP_LOAD, !rsp_valid_ff, "load gave a result")

endmodule

>>> hdl/rc4_keystream_generator.sv
// Draw transaction: busy in the DJ, DWI and DWJ states after accept; rsp_valid strobes as the
// sequencer returns to idle; no new draw is taken while busy. Load transaction: the last key
// byte runs an identity fill and 256 swap steps with busy high; other key bytes leave busy low.
// Reset: identity fill of all 256 state table entries with busy high; indices and key count zero.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// rc4_keystream_generator
// RC4 byte generator: buffers key bytes, runs the key schedule on the last
// one and returns one keystream byte per draw transaction.
// ----------------------------------------------------------------------------
module rc4_keystream_generator (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  rc4ks_pkg::byte_type req_key_byte,
   input  logic                req_key_last,
   output logic                rsp_valid,
   output rc4ks_pkg::byte_type rsp_random_byte
);
   import rc4ks_pkg::*;

   logic       accept;
   key_wr_type key_wr;
   byte_type   key_rd_addr;
   byte_type   key_rd_data;
   kcnt_type   sched_len;

   // take a transaction when idle
   assign accept      = start && !busy;
   assign key_wr.valid = accept && (req_operation == OP_LOAD);
   assign key_wr.data  = req_key_byte;
   assign key_wr.last  = req_key_last;

   rc4ks_key_buf u_key_buf (
      .clock     (clock),
      .reset     (reset),
      .key_wr    (key_wr),
      .rd_addr   (key_rd_addr),
      .rd_data   (key_rd_data),
      .sched_len (sched_len)
   );

   rc4ks_perm_engine u_perm_engine (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .operation       (req_operation),
      .key_last        (req_key_last),
      .sched_len       (sched_len),
      .key_rd_addr     (key_rd_addr),
      .key_rd_data     (key_rd_data),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_random_byte (rsp_random_byte)
   );

endmodule
